// ===== rtl/hls_pkg.sv =====
package hls_pkg;

  // Field and register widths
  localparam int PIX_W     = 16;
  localparam int SUM_W     = 18;
  localparam int CFG_W     = 16;
  localparam int RLEN_W    = 11;
  localparam int DIM_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SUM_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_SAMPLE = 3'd4;

  // Local sum modes
  typedef enum logic [1:0] {
    MODE_WIDE_NBR   = 2'd0,
    MODE_NARROW_NBR = 2'd1,
    MODE_WIDE_COL   = 2'd2,
    MODE_NARROW_COL = 2'd3
  } sum_mode_t;

  // Position flags of one item
  typedef struct packed {
    logic r0;         // first row of the band
    logic x0;         // first column
    logic col_end;    // last column (or past it)
    logic zpos;       // band index above zero
    logic image_end;  // last sample of the image
  } pos_info_t;

endpackage

// ===== rtl/hls_pos_ctrl.sv =====
module hls_pos_ctrl
  import hls_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [RLEN_W-1:0]                 row_length,
  input  logic [DIM_W-1:0]                  row_count,
  input  logic [DIM_W-1:0]                  band_count,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0] x,
  output pos_info_t                         info
);

  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam int LW = (AW + 1 > RLEN_W) ? AW + 1 : RLEN_W;

  logic [AW-1:0]    col;
  logic [DIM_W-1:0] row;
  logic [DIM_W-1:0] band;
  logic [LW-1:0]    rl;
  logic [AW-1:0]    last;
  logic [DIM_W-1:0] rows_last;
  logic [DIM_W-1:0] bands_last;
  logic             col_end;
  logic             row_end;
  logic             band_end;

  // Effective last column, row length clamped to [2, MAX_ROW_LENGTH]
  assign rl = LW'(row_length);
  always_comb begin
    if (rl < LW'(2)) begin
      last = AW'(1);
    end else if (rl > LW'(MAX_ROW_LENGTH)) begin
      last = AW'(MAX_ROW_LENGTH - 1);
    end else begin
      last = AW'(rl - LW'(1));
    end
  end

  // Zero rows or bands count as one
  assign rows_last  = (row_count == '0) ? '0 : row_count - DIM_W'(1);
  assign bands_last = (band_count == '0) ? '0 : band_count - DIM_W'(1);

  assign col_end  = (col >= last);
  assign row_end  = (row >= rows_last);
  assign band_end = (band >= bands_last);

  assign x              = col;
  assign info.r0        = (row == '0);
  assign info.x0        = (col == '0);
  assign info.col_end   = col_end;
  assign info.zpos      = (band != '0);
  assign info.image_end = col_end && row_end && band_end;

  // Raster position: column, then row, then band
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      band <= '0;
    end else if (advance) begin
      if (!col_end) begin
        col <= AW'(col + 1'b1);
      end else begin
        col <= '0;
        if (!row_end) begin
          row <= row + DIM_W'(1);
        end else begin
          row  <= '0;
          band <= band_end ? '0 : band + DIM_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/hls_line_buf.sv =====
module hls_line_buf
  import hls_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int SW             = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [$clog2(MAX_ROW_LENGTH)-1:0] x,
  input  logic                              row0,
  input  logic [SW-1:0]                     pixel,
  output logic [SW-1:0]                     w,
  output logic [SW-1:0]                     nw,
  output logic [SW-1:0]                     n,
  output logic [SW-1:0]                     ne,
  output logic [SW-1:0]                     p
);

  localparam int            AW        = $clog2(MAX_ROW_LENGTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ROW_LENGTH - 1);

  // Previous row of this band, first row of the previous band
  logic [SW-1:0] above_mem [MAX_ROW_LENGTH];
  logic [SW-1:0] top_mem   [MAX_ROW_LENGTH];

  logic [AW-1:0] ne_addr;
  logic [SW-1:0] n_q;
  logic [SW-1:0] ne_q;
  logic [SW-1:0] pt_q;
  logic          pt_valid;
  logic          ne_zero;
  logic [SW-1:0] pix_q;

  // No upper-right neighbor past the end of the buffer
  assign ne_addr = (x == LAST_ADDR) ? '0 : AW'(x + 1'b1);

  // Read-before-write: an item reads old contents and stores its own pixel
  // at the same edge, so the item in the same column of the next row sees it.
  always_ff @(posedge clk) begin
    if (advance) begin
      n_q            <= above_mem[x];
      ne_q           <= above_mem[ne_addr];
      above_mem[x]   <= pixel;
      pt_q           <= top_mem[x];
      if (row0) begin
        top_mem[x] <= pixel;
      end
    end
  end

  // Neighbor registers carried from the previous item
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_q    <= '0;
      w        <= '0;
      nw       <= '0;
      p        <= '0;
      pt_valid <= 1'b0;
      ne_zero  <= 1'b0;
    end else if (advance) begin
      pix_q    <= pixel;
      w        <= pix_q;
      nw       <= n_q;
      if (pt_valid) begin
        p <= pt_q;
      end
      pt_valid <= row0;
      ne_zero  <= (x == LAST_ADDR);
    end
  end

  assign n  = n_q;
  assign ne = ne_zero ? '0 : ne_q;

endmodule

// ===== rtl/hls_sum.sv =====
module hls_sum
  import hls_pkg::*;
#(
  parameter int SW = 16
) (
  input  sum_mode_t         mode,
  input  logic [PIX_W-1:0]  mid_sample,
  input  pos_info_t         info,
  input  logic [SW-1:0]     w,
  input  logic [SW-1:0]     nw,
  input  logic [SW-1:0]     n,
  input  logic [SW-1:0]     ne,
  input  logic [SW-1:0]     p,
  output logic [SUM_W-1:0]  local_sum
);

  logic [SUM_W-1:0] w_e, nw_e, n_e, ne_e, p_e, m4;

  assign w_e  = SUM_W'(w);
  assign nw_e = SUM_W'(nw);
  assign n_e  = SUM_W'(n);
  assign ne_e = SUM_W'(ne);
  assign p_e  = SUM_W'(p);
  assign m4   = {mid_sample, 2'b00};

  // Edge rules per mode; first sample of a band is always 4*mid
  always_comb begin
    local_sum = m4;
    if (!(info.r0 && info.x0)) begin
      case (mode)
        MODE_WIDE_NBR: begin
          if (info.r0)            local_sum = w_e << 2;
          else if (info.x0)       local_sum = (n_e + ne_e) << 1;
          else if (!info.col_end) local_sum = w_e + nw_e + n_e + ne_e;
          else                    local_sum = w_e + nw_e + (n_e << 1);
        end
        MODE_NARROW_NBR: begin
          if (info.r0)            local_sum = info.zpos ? (p_e << 2) : m4;
          else if (info.x0)       local_sum = (n_e + ne_e) << 1;
          else if (!info.col_end) local_sum = nw_e + (n_e << 1) + ne_e;
          else                    local_sum = (nw_e + n_e) << 1;
        end
        MODE_WIDE_COL: begin
          local_sum = info.r0 ? (w_e << 2) : (n_e << 2);
        end
        MODE_NARROW_COL: begin
          if (!info.r0)           local_sum = n_e << 2;
          else                    local_sum = info.zpos ? (p_e << 2) : m4;
        end
        default: local_sum = m4;
      endcase
    end
  end

endmodule

// ===== rtl/hyperspectral_local_sum.sv =====
// Local sum stage for a band-sequential hyperspectral predictor.
// Input channel: pixel with in_valid/in_ready, samples in band, row, column
// order. Output channel: local_sum, band_start, image_end with
// out_valid/out_ready, one result item per input item, in order.
// Configuration: cfg_we/cfg_index/cfg_data, taken at any edge with cfg_we
// high; write only while no item is in flight.
// Path: an accepted item's reads are registered in the read stage, then its
// result is registered in the output register, which drives out_valid.
// Throughput: one item per cycle while out_ready is high. Each item does one
// read-modify-write of the two line buffers (two reads of the row buffer, one
// of the first-row buffer) at its accept edge; sum uses the registered reads.
// Stall: when out_ready is low the output register holds its item and one
// more item is taken into the read stage; in_ready then drops.
// Reset: counters and neighbor registers clear, registers take their
// defaults (wide neighbor, 1024 columns, 1024 rows, one band, mid 32768).
// Line buffers are not cleared; every entry is written before it is used.
module hyperspectral_local_sum
  import hls_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SUM_W-1:0]     local_sum,
  output logic                 band_start,
  output logic                 image_end
);

  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam int SW = (SAMPLE_BITS < PIX_W) ? SAMPLE_BITS : PIX_W;

  sum_mode_t         sum_mode;
  logic [RLEN_W-1:0] row_length;
  logic [DIM_W-1:0]  row_count;
  logic [DIM_W-1:0]  band_count;
  logic [PIX_W-1:0]  mid_sample;

  logic              accept;
  logic              s1_valid;
  logic              s1_adv;
  pos_info_t         info;
  pos_info_t         s1_info;
  logic [AW-1:0]     x;
  logic [SW-1:0]     w, nw, n, ne, p;
  logic [SUM_W-1:0]  sum;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_mode   <= MODE_WIDE_NBR;
      row_length <= RLEN_W'(1024);
      row_count  <= DIM_W'(1024);
      band_count <= DIM_W'(1);
      mid_sample <= PIX_W'(32768);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUM_MODE:   sum_mode   <= sum_mode_t'(cfg_data[1:0]);
        REG_ROW_LENGTH: row_length <= cfg_data[RLEN_W-1:0];
        REG_ROW_COUNT:  row_count  <= cfg_data[DIM_W-1:0];
        REG_BAND_COUNT: band_count <= cfg_data[DIM_W-1:0];
        REG_MID_SAMPLE: mid_sample <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Two-stage flow: read stage, then output register
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  hls_pos_ctrl #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_pos (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .row_length (row_length),
    .row_count  (row_count),
    .band_count (band_count),
    .x          (x),
    .info       (info)
  );

  hls_line_buf #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .SW            (SW)
  ) u_buf (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .x       (x),
    .row0    (info.r0),
    .pixel   (pixel[SW-1:0]),
    .w       (w),
    .nw      (nw),
    .n       (n),
    .ne      (ne),
    .p       (p)
  );

  hls_sum #(
    .SW(SW)
  ) u_sum (
    .mode       (sum_mode),
    .mid_sample (mid_sample),
    .info       (s1_info),
    .w          (w),
    .nw         (nw),
    .n          (n),
    .ne         (ne),
    .p          (p),
    .local_sum  (sum)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      local_sum  <= sum;
      band_start <= s1_info.r0 && s1_info.x0;
      image_end  <= s1_info.image_end;
    end
  end

endmodule
